// ----- rtl/pols_pkg.sv -----
// Shared types, request and status codes, and FSM states for the positional list store.
// No dependencies; the list store and both testbench files import this package.
package pols_pkg;

    localparam int CAPACITY_DEF = 64;

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_DELETE = 2'd1;
    localparam logic [1:0] REQ_READ   = 2'd2;
    localparam logic [1:0] REQ_FIND   = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BADPOS   = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [6:0]         position;
        logic signed [31:0] value;
    } t_req;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic [6:0]         found_position;
        logic [6:0]         entry_count;
        logic               is_empty;
        logic [1:0]         status;
    } t_resp;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT_UP,
        S_INS_WR,
        S_DEL_RD,
        S_SHIFT_DN,
        S_RD_WAIT,
        S_FIND,
        S_DONE
    } t_state;

endpackage

// ----- rtl/pols_ram.sv -----
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
module pols_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/positional_ordered_list_store.sv -----
// Positional list store: an ordered list of signed 32-bit values kept in one RAM.
// Depends on pols_pkg and pols_ram.
//
// Usage: a request beat on the input channel (i_in_valid / o_in_stall, payload
// i_in_data) carries a request type, a one-based position and a value. Insert,
// delete, read-at-position and find-value each return exactly one result beat on
// the output channel (o_out_valid / i_out_stall, payload o_out_data) with the
// value, the found position, the entry count after the request, an empty flag
// and a status code. One request is worked at a time; o_in_stall is high from
// acceptance until its result is loaded into the output register.
// The work per request is set by the single RAM read port that moves one entry
// per cycle: errors and appends go straight to the result; read waits for the
// RAM read; insert at p shifts entries p..count up, then writes; delete at p
// reads the entry, shifts those above it down; find scans to the first match.
// The output register holds a result while the receiver stalls; the next
// request is still accepted and worked, waiting in its final state until the
// register frees. Reset empties the list (count to zero); the RAM
// contents are not cleared since only entries below the count are ever read.
module positional_ordered_list_store #(
    parameter int CAPACITY = pols_pkg::CAPACITY_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  pols_pkg::t_req i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output pols_pkg::t_resp o_out_data
);
    import pols_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = ((CW > 7) ? CW : 7) + 1;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [AW-1:0]   r_ptr, n_ptr;
    logic [AW-1:0]   r_tgt, n_tgt;
    logic [31:0]     r_val, n_val;
    logic [31:0]     r_rv, n_rv;
    logic [6:0]      r_fpos, n_fpos;
    logic [1:0]      r_st, n_st;
    logic            r_out_valid, n_out_valid;
    t_resp           r_out, n_out;

    logic            ram_we, ram_re;
    logic [AW-1:0]   ram_waddr, ram_raddr;
    logic [31:0]     ram_wdata, ram_rdata;

    logic [XW-1:0]   pos_x, cnt_x, ptr_x, tgt_x;
    logic [AW-1:0]   pos_m1, cnt_m1, ptr_m1, ptr_m2, ptr_p1, tgt_p1;
    logic            ins_bad, is_full, acc_bad, is_append, cnt_zero;
    logic            up_last, dn_more, del_more, out_free;

    pols_ram #(
        .WIDTH(32),
        .DEPTH(CAPACITY)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    // Request decode and pointer arithmetic
    always_comb begin
        pos_x     = XW'(i_in_data.position);
        cnt_x     = XW'(r_count);
        ptr_x     = XW'(r_ptr);
        tgt_x     = XW'(r_tgt);
        pos_m1    = AW'(pos_x - XW'(1));
        cnt_m1    = AW'(cnt_x - XW'(1));
        ptr_m1    = r_ptr - AW'(1);
        ptr_m2    = ptr_m1 - AW'(1);
        ptr_p1    = AW'(ptr_x + XW'(1));
        tgt_p1    = AW'(tgt_x + XW'(1));
        ins_bad   = (pos_x == '0) || (pos_x > cnt_x + XW'(1));
        is_full   = (cnt_x == XW'(CAPACITY));
        acc_bad   = (pos_x == '0) || (pos_x > cnt_x);
        is_append = (pos_x == cnt_x + XW'(1));
        cnt_zero  = (r_count == '0);
        up_last   = (ptr_m1 == r_tgt);
        dn_more   = (ptr_x + XW'(1) < cnt_x);
        del_more  = (tgt_x + XW'(1) < cnt_x);
        out_free  = !r_out_valid || !i_out_stall;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_in_data.req_type)
                        REQ_INSERT: begin
                            if (ins_bad || is_full || is_append) begin
                                n_state = S_DONE;
                            end else begin
                                n_state = S_SHIFT_UP;
                            end
                        end
                        REQ_DELETE: n_state = acc_bad ? S_DONE : S_DEL_RD;
                        REQ_READ:   n_state = acc_bad ? S_DONE : S_RD_WAIT;
                        REQ_FIND:   n_state = cnt_zero ? S_DONE : S_FIND;
                        default:    n_state = S_DONE;
                    endcase
                end
            end
            S_SHIFT_UP: n_state = up_last ? S_INS_WR : S_SHIFT_UP;
            S_INS_WR:   n_state = S_DONE;
            S_DEL_RD:   n_state = del_more ? S_SHIFT_DN : S_DONE;
            S_SHIFT_DN: n_state = dn_more ? S_SHIFT_DN : S_DONE;
            S_RD_WAIT:  n_state = S_DONE;
            S_FIND: begin
                if ((ram_rdata == r_val) || !dn_more) begin
                    n_state = S_DONE;
                end
            end
            S_DONE:     n_state = out_free ? S_IDLE : S_DONE;
            default:    n_state = S_IDLE;
        endcase
    end

    // RAM control and datapath
    always_comb begin
        ram_we      = 1'b0;
        ram_waddr   = r_ptr;
        ram_wdata   = ram_rdata;
        ram_re      = 1'b0;
        ram_raddr   = r_ptr;
        n_count     = r_count;
        n_ptr       = r_ptr;
        n_tgt       = r_tgt;
        n_val       = r_val;
        n_rv        = r_rv;
        n_fpos      = r_fpos;
        n_st        = r_st;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        o_in_stall  = (r_state != S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_val  = i_in_data.value;
                    n_rv   = '0;
                    n_fpos = '0;
                    n_st   = ST_OK;
                    n_tgt  = pos_m1;
                    case (i_in_data.req_type)
                        REQ_INSERT: begin
                            if (ins_bad) begin
                                n_st = ST_BADPOS;
                            end else if (is_full) begin
                                n_st = ST_FULL;
                            end else if (is_append) begin
                                ram_we    = 1'b1;
                                ram_waddr = AW'(r_count);
                                ram_wdata = i_in_data.value;
                                n_count   = r_count + CW'(1);
                                n_rv      = i_in_data.value;
                            end else begin
                                // start the upward shift from the last entry
                                ram_re    = 1'b1;
                                ram_raddr = cnt_m1;
                                n_ptr     = AW'(r_count);
                                n_rv      = i_in_data.value;
                            end
                        end
                        REQ_DELETE, REQ_READ: begin
                            if (acc_bad) begin
                                n_st = ST_BADPOS;
                            end else begin
                                ram_re    = 1'b1;
                                ram_raddr = pos_m1;
                            end
                        end
                        REQ_FIND: begin
                            if (cnt_zero) begin
                                n_st = ST_NOTFOUND;
                            end else begin
                                ram_re    = 1'b1;
                                ram_raddr = '0;
                                n_ptr     = '0;
                            end
                        end
                        default: n_st = ST_BADPOS;
                    endcase
                end
            end
            S_SHIFT_UP: begin
                // move entry ptr-1 up to ptr, prefetch the one below
                ram_we    = 1'b1;
                ram_waddr = r_ptr;
                ram_wdata = ram_rdata;
                if (!up_last) begin
                    ram_re    = 1'b1;
                    ram_raddr = ptr_m2;
                    n_ptr     = ptr_m1;
                end
            end
            S_INS_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_tgt;
                ram_wdata = r_val;
                n_count   = r_count + CW'(1);
            end
            S_DEL_RD: begin
                n_rv = ram_rdata;
                if (del_more) begin
                    ram_re    = 1'b1;
                    ram_raddr = tgt_p1;
                    n_ptr     = tgt_p1;
                end else begin
                    n_count = r_count - CW'(1);
                end
            end
            S_SHIFT_DN: begin
                // move entry ptr down to ptr-1, prefetch the one above
                ram_we    = 1'b1;
                ram_waddr = ptr_m1;
                ram_wdata = ram_rdata;
                if (dn_more) begin
                    ram_re    = 1'b1;
                    ram_raddr = ptr_p1;
                    n_ptr     = ptr_p1;
                end else begin
                    n_count = r_count - CW'(1);
                end
            end
            S_RD_WAIT: begin
                n_rv = ram_rdata;
            end
            S_FIND: begin
                if (ram_rdata == r_val) begin
                    n_fpos = 7'(ptr_x + XW'(1));
                end else if (dn_more) begin
                    ram_re    = 1'b1;
                    ram_raddr = ptr_p1;
                    n_ptr     = ptr_p1;
                end else begin
                    n_st = ST_NOTFOUND;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid          = 1'b1;
                    n_out.result_value   = r_rv;
                    n_out.found_position = r_fpos;
                    n_out.entry_count    = 7'(r_count);
                    n_out.is_empty       = cnt_zero;
                    n_out.status         = r_st;
                end
            end
            default: begin
                n_st = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr  <= n_ptr;
        r_tgt  <= n_tgt;
        r_val  <= n_val;
        r_rv   <= n_rv;
        r_fpos <= n_fpos;
        r_st   <= n_st;
        r_out  <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ----- tb/pols_tb_pkg.sv -----
`timescale 1ns / 100ps
// Scoreboard for the positional list store: a behavioral copy of the list
// and the queue of responses it predicts. Depends on pols_pkg.
package pols_tb_pkg;

    import pols_pkg::*;

    localparam int LIST_CAP = CAPACITY_DEF;

    class list_scoreboard;

        logic signed [31:0] entries [LIST_CAP];
        int                 count;
        t_resp              pending [$];
        int                 n_errors;

        function new();
            count    = 0;
            n_errors = 0;
        endfunction

        // Apply one accepted request to the list copy and queue its response.
        function void note_request(t_req r);
            t_resp exp_r;
            int    pos;
            int    i;
            exp_r = '0;
            pos   = r.position;
            case (r.req_type)
                REQ_INSERT: begin
                    if (pos < 1 || pos > count + 1) begin
                        exp_r.status = ST_BADPOS;
                    end else if (count >= LIST_CAP) begin
                        exp_r.status = ST_FULL;
                    end else begin
                        for (i = count; i >= pos; i--)
                            entries[i] = entries[i - 1];
                        entries[pos - 1] = r.value;
                        count++;
                        exp_r.result_value = r.value;
                    end
                end
                REQ_DELETE: begin
                    if (pos < 1 || pos > count) begin
                        exp_r.status = ST_BADPOS;
                    end else begin
                        exp_r.result_value = entries[pos - 1];
                        for (i = pos; i < count; i++)
                            entries[i - 1] = entries[i];
                        count--;
                    end
                end
                REQ_READ: begin
                    if (pos < 1 || pos > count)
                        exp_r.status = ST_BADPOS;
                    else
                        exp_r.result_value = entries[pos - 1];
                end
                REQ_FIND: begin
                    exp_r.status = ST_NOTFOUND;
                    for (i = 0; i < count; i++) begin
                        if (entries[i] == r.value) begin
                            exp_r.found_position = 7'(i + 1);
                            exp_r.status         = ST_OK;
                            break;
                        end
                    end
                end
            endcase
            exp_r.entry_count = 7'(count);
            exp_r.is_empty    = (count == 0);
            pending.push_back(exp_r);
        endfunction

        function void check_response(t_resp got);
            t_resp exp_r;
            if (pending.size() == 0) begin
                $error("response beat with nothing outstanding");
                n_errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (got.result_value !== exp_r.result_value) begin
                $error("result_value expected %0d got %0d", exp_r.result_value,
                       got.result_value);
                n_errors++;
            end
            if (got.found_position !== exp_r.found_position) begin
                $error("found_position expected %0d got %0d", exp_r.found_position,
                       got.found_position);
                n_errors++;
            end
            if (got.entry_count !== exp_r.entry_count) begin
                $error("entry_count expected %0d got %0d", exp_r.entry_count,
                       got.entry_count);
                n_errors++;
            end
            if (got.is_empty !== exp_r.is_empty) begin
                $error("is_empty expected %0d got %0d", exp_r.is_empty, got.is_empty);
                n_errors++;
            end
            if (got.status !== exp_r.status) begin
                $error("status expected %0d got %0d", exp_r.status, got.status);
                n_errors++;
            end
        endfunction

    endclass

endpackage

// ----- tb/positional_ordered_list_store_tb.sv -----
`timescale 1ns / 100ps
// Top-level testbench for positional_ordered_list_store: directed and random
// requests with random idling on both channels. Depends on pols_pkg, pols_tb_pkg.
module positional_ordered_list_store_tb;

    import pols_pkg::*;
    import pols_tb_pkg::*;

    localparam int N_RANDOM    = 1850;
    localparam int CALM_AT     = 1650;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_WAIT  = 100;

    typedef enum int {MODE_GROW, MODE_MIXED, MODE_SHRINK} t_gen_mode;

    logic  i_clk    = 1'b0;
    logic  i_rst_n  = 1'b0;
    logic  in_valid = 1'b0;
    t_req  in_data  = '0;
    logic  out_stall = 1'b0;
    logic  o_in_stall;
    logic  o_out_valid;
    t_resp out_data;

    int    idle_pct = 20;
    int    n_cycles = 0;
    list_scoreboard sb;

    positional_ordered_list_store u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data)
    );

    initial begin : clk_gen
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("positional_ordered_list_store test failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !out_stall)
            sb.check_response(out_data);
    end

    // Receiver: stall in random bursts while idling is enabled.
    initial begin : out_side
        int burst;
        burst = 0;
        forever begin
            @(negedge i_clk);
            if (burst == 0 && idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
                burst = $urandom_range(1, 7);
            if (burst > 0) begin
                out_stall <= 1'b1;
                burst--;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    function automatic t_req mk_req(logic [1:0] kind, int pos, logic [31:0] val);
        t_req r;
        r.req_type = kind;
        r.position = 7'(pos);
        r.value    = val;
        return r;
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0;
            3:       return 32'hffff_ffff;
            4, 5, 6: return $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    function automatic t_req next_req(t_gen_mode mode);
        t_req r;
        int   roll;
        int   n;
        n    = sb.count;
        roll = $urandom_range(0, 99);
        // Noise: any code, any position including the unused upper range.
        if ($urandom_range(0, 99) < 8)
            return mk_req(2'($urandom_range(0, 3)), $urandom_range(0, 127), $urandom);
        case (mode)
            MODE_GROW:   r.req_type = roll < 70 ? REQ_INSERT : roll < 80 ? REQ_DELETE :
                                      roll < 90 ? REQ_READ : REQ_FIND;
            MODE_SHRINK: r.req_type = roll < 15 ? REQ_INSERT : roll < 70 ? REQ_DELETE :
                                      roll < 85 ? REQ_READ : REQ_FIND;
            default:     r.req_type = roll < 30 ? REQ_INSERT : roll < 55 ? REQ_DELETE :
                                      roll < 75 ? REQ_READ : REQ_FIND;
        endcase
        r.value = pick_value();
        case (r.req_type)
            REQ_INSERT: r.position = ($urandom_range(0, 3) == 0) ? 7'(n + 1)
                                                                 : 7'($urandom_range(1, n + 1));
            REQ_FIND: begin
                r.position = 7'($urandom_range(0, 127));
                if (n > 0 && $urandom_range(0, 9) < 7)
                    r.value = sb.entries[$urandom_range(0, n - 1)];
            end
            default:    r.position = (n == 0) ? 7'd1 : 7'($urandom_range(1, n));
        endcase
        return r;
    endfunction

    task automatic send_req(input t_req r);
        int gap;
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            gap = $urandom_range(1, 7);
            @(negedge i_clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_valid <= 1'b1;
        in_data  <= r;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_request(r);
    endtask

    initial begin : main
        int        n_random;
        int        seg_len;
        int        tail;
        t_gen_mode mode;
        sb       = new();
        n_random = 0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty-list errors, extreme values, bad positions, duplicates.
        send_req(mk_req(REQ_READ,   1, 32'd0));
        send_req(mk_req(REQ_DELETE, 1, 32'd0));
        send_req(mk_req(REQ_FIND,   0, 32'd0));
        send_req(mk_req(REQ_INSERT, 0, 32'd5));
        send_req(mk_req(REQ_INSERT, 2, 32'd5));
        send_req(mk_req(REQ_INSERT, 1, 32'h8000_0000));
        send_req(mk_req(REQ_INSERT, 2, 32'h7fff_ffff));
        send_req(mk_req(REQ_INSERT, 1, 32'hffff_ffff));
        send_req(mk_req(REQ_INSERT, 2, 32'h0));
        send_req(mk_req(REQ_INSERT, 5, 32'h7fff_ffff));
        send_req(mk_req(REQ_FIND,   0, 32'h7fff_ffff));
        send_req(mk_req(REQ_FIND,   0, 32'd12345));
        send_req(mk_req(REQ_READ,   0, 32'd0));
        send_req(mk_req(REQ_READ,   6, 32'd0));
        send_req(mk_req(REQ_READ, 127, 32'hffff_ffff));
        send_req(mk_req(REQ_READ,   5, 32'd0));
        send_req(mk_req(REQ_DELETE, 127, 32'd0));
        send_req(mk_req(REQ_DELETE, 5, 32'd0));
        send_req(mk_req(REQ_DELETE, 1, 32'd0));
        send_req(mk_req(REQ_DELETE, 2, 32'd0));
        send_req(mk_req(REQ_READ,   1, 32'd0));
        send_req(mk_req(REQ_FIND, 127, 32'h0));
        send_req(mk_req(REQ_DELETE, 1, 32'd0));
        send_req(mk_req(REQ_DELETE, 1, 32'd0));
        send_req(mk_req(REQ_DELETE, 1, 32'd0));

        // Random: fill to capacity, churn, drain to empty, churn, repeat.
        mode = MODE_GROW;
        while (n_random < N_RANDOM) begin
            case ($urandom_range(0, 3))
                0:       idle_pct = 0;
                1:       idle_pct = 10;
                default: idle_pct = 30;
            endcase
            seg_len = 0;
            tail    = 0;
            while (n_random < N_RANDOM && seg_len < 400 &&
                   (mode == MODE_MIXED ? seg_len < 150 : tail < 10)) begin
                if (n_random >= CALM_AT)
                    idle_pct = 0;
                send_req(next_req(mode));
                n_random++;
                seg_len++;
                if ((mode == MODE_GROW && sb.count == LIST_CAP) ||
                    (mode == MODE_SHRINK && sb.count == 0) || tail > 0)
                    tail++;
            end
            case (mode)
                MODE_GROW:   mode = MODE_MIXED;
                MODE_MIXED:  mode = (sb.count > LIST_CAP / 2) ? MODE_SHRINK : MODE_GROW;
                default:     mode = MODE_MIXED;
            endcase
        end

        @(negedge i_clk);
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (sb.n_errors == 0)
            $display("positional_ordered_list_store test passed");
        else
            $display("positional_ordered_list_store test failed");
        $finish;
    end

endmodule
